>>> rtl/mpa_pkg.sv
// Package: shared types for the matrix pair arithmetic block.
package mpa_pkg;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MAC,
		ST_ELEM,
		ST_DRAIN
	} mpa_state_t;

	// Control travelling with read data into the multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic take;
	} mac_ctrl_t;

endpackage

>>> rtl/mpa_in_if.sv
// Interface: input channel carrying one X/Y element pair per transaction.
interface mpa_in_if #(
	parameter int ELEM_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [ELEM_WIDTH-1:0] x_element;
	logic signed [ELEM_WIDTH-1:0] y_element;

	modport source (output valid, output x_element, output y_element, input ready);
	modport sink   (input valid, input x_element, input y_element, output ready);
endinterface

>>> rtl/mpa_out_if.sv
// Interface: result channel carrying one element position per transaction.
interface mpa_out_if #(
	parameter int ELEM_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [ELEM_WIDTH:0]     sum;
	logic signed [ELEM_WIDTH:0]     difference;
	logic signed [2*ELEM_WIDTH+1:0] product;
	logic signed [ELEM_WIDTH-1:0]   larger;
	logic signed [ELEM_WIDTH-1:0]   smaller;
	logic                           last;

	modport source (output valid, output sum, output difference, output product,
		output larger, output smaller, output last, input ready);
	modport sink   (input valid, input sum, input difference, input product,
		input larger, input smaller, input last, output ready);
endinterface

>>> rtl/matrix_pair_arithmetic.sv
// Top level: loads an X/Y matrix pair, then emits per-position sum, difference, matrix product, max, min.
// Loading: one pair transaction per cycle, SIDE*SIDE transactions fill both stores.
// Results: each position takes SIDE reads through the one multiplier, one element read, then the
//   multiplier and accumulator registers.
// The next result is computed while the previous one waits in the output register.
// Reset clears the sequencer, counters and valid flags; element stores are not cleared.
module matrix_pair_arithmetic #(
	parameter int SIDE       = 4,
	parameter int ELEM_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	mpa_in_if.sink    operands,
	mpa_out_if.source results
);
	import mpa_pkg::*;

	localparam int CELLS  = SIDE * SIDE;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int IDX_W  = $clog2(SIDE);
	localparam int PW     = 2 * ELEM_WIDTH + 2;
	localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(SIDE - 1);
	localparam logic [ADDR_W-1:0] CELL_MAX = ADDR_W'(CELLS - 1);

	mpa_state_t state_q;
	mpa_state_t state_nxt;

	logic [ADDR_W-1:0] load_count_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [IDX_W-1:0]  k_q;

	logic              load_acc;   // pair transaction taken
	logic              emit;       // finished position moves into the output register
	logic [ADDR_W-1:0] x_raddr;
	logic [ADDR_W-1:0] y_raddr;
	logic              mac_rd;     // this cycle reads a row/column operand pair
	logic              elem_rd;    // this cycle reads the element pair at (row, col)

	logic signed [ELEM_WIDTH-1:0] x_rd;
	logic signed [ELEM_WIDTH-1:0] y_rd;

	// read-side flags, aligned with RAM output data
	logic rd_v_s1;
	logic rd_first_s1;
	logic rd_last_s1;
	logic elem_s1;

	logic signed [ELEM_WIDTH-1:0] x_e_q;
	logic signed [ELEM_WIDTH-1:0] y_e_q;

	mac_ctrl_t            mac_ctrl;
	logic signed [PW-1:0] mac_acc;
	logic                 mac_done;

	// output register
	logic                           out_valid_q;
	logic signed [ELEM_WIDTH:0]     sum_q;
	logic signed [ELEM_WIDTH:0]     diff_q;
	logic signed [PW-1:0]           prod_q;
	logic signed [ELEM_WIDTH-1:0]   larger_q;
	logic signed [ELEM_WIDTH-1:0]   smaller_q;
	logic                           last_q;

	logic [ADDR_W-1:0] elem_addr;

	assign elem_addr = ADDR_W'(row_q) * ADDR_W'(SIDE) + ADDR_W'(col_q);

	// ---------------------------------------------------------------
	// Element stores: written in load order, read by the sequencer
	// ---------------------------------------------------------------
	mpa_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CELLS)) u_x_store (
		.clk   (clk),
		.we    (load_acc),
		.waddr (load_count_q),
		.wdata (operands.x_element),
		.raddr (x_raddr),
		.rdata (x_rd)
	);

	mpa_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CELLS)) u_y_store (
		.clk   (clk),
		.we    (load_acc),
		.waddr (load_count_q),
		.wdata (operands.y_element),
		.raddr (y_raddr),
		.rdata (y_rd)
	);

	// ---------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (load_acc && load_count_q == CELL_MAX) begin
					state_nxt = ST_MAC;
				end
			end
			ST_MAC: begin
				if (k_q == IDX_MAX) begin
					state_nxt = ST_ELEM;
				end
			end
			ST_ELEM: begin
				state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (emit) begin
					state_nxt = (row_q == IDX_MAX && col_q == IDX_MAX) ? ST_LOAD : ST_MAC;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: outputs
	// ---------------------------------------------------------------
	always_comb begin
		operands.ready = 1'b0;
		mac_rd         = 1'b0;
		elem_rd        = 1'b0;
		emit           = 1'b0;
		x_raddr        = elem_addr;
		y_raddr        = elem_addr;
		case (state_q)
			ST_LOAD: begin
				operands.ready = 1'b1;
			end
			ST_MAC: begin
				mac_rd  = 1'b1;
				x_raddr = ADDR_W'(row_q) * ADDR_W'(SIDE) + ADDR_W'(k_q);
				y_raddr = ADDR_W'(k_q) * ADDR_W'(SIDE) + ADDR_W'(col_q);
			end
			ST_ELEM: begin
				elem_rd = 1'b1;
			end
			ST_DRAIN: begin
				// wait for the dot product, and for room in the output register
				emit = mac_done && (!out_valid_q || results.ready);
			end
			default: begin
				operands.ready = 1'b0;
			end
		endcase
	end

	assign load_acc = operands.valid && operands.ready;

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_count_q <= '0;
			row_q        <= '0;
			col_q        <= '0;
			k_q          <= '0;
			rd_v_s1      <= 1'b0;
			rd_first_s1  <= 1'b0;
			rd_last_s1   <= 1'b0;
			elem_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rd_v_s1     <= mac_rd;
			rd_first_s1 <= mac_rd && (k_q == '0);
			rd_last_s1  <= mac_rd && (k_q == IDX_MAX);
			elem_s1     <= elem_rd;

			if (load_acc) begin
				load_count_q <= (load_count_q == CELL_MAX) ? '0 : load_count_q + 1'b1;
			end

			if (mac_rd) begin
				k_q <= (k_q == IDX_MAX) ? '0 : k_q + 1'b1;
			end

			// step to the next position in row-major order
			if (emit) begin
				if (col_q == IDX_MAX) begin
					col_q <= '0;
					row_q <= (row_q == IDX_MAX) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (elem_s1) begin
			x_e_q <= x_rd;
			y_e_q <= y_rd;
		end
		if (emit) begin
			sum_q     <= (ELEM_WIDTH+1)'(x_e_q) + (ELEM_WIDTH+1)'(y_e_q);
			diff_q    <= (ELEM_WIDTH+1)'(x_e_q) - (ELEM_WIDTH+1)'(y_e_q);
			prod_q    <= mac_acc;
			larger_q  <= (x_e_q > y_e_q) ? x_e_q : y_e_q;   // Y on a tie
			smaller_q <= (x_e_q < y_e_q) ? x_e_q : y_e_q;
			last_q    <= (row_q == IDX_MAX) && (col_q == IDX_MAX);
		end
	end

	// ---------------------------------------------------------------
	// Shared multiply-accumulate unit
	// ---------------------------------------------------------------
	always_comb begin
		mac_ctrl.valid = rd_v_s1;
		mac_ctrl.first = rd_first_s1;
		mac_ctrl.last  = rd_last_s1;
		mac_ctrl.take  = emit;
	end

	mpa_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (x_rd),
		.b      (y_rd),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// ---------------------------------------------------------------
	// Result channel
	// ---------------------------------------------------------------
	assign results.valid      = out_valid_q;
	assign results.sum        = sum_q;
	assign results.difference = diff_q;
	assign results.product    = prod_q;
	assign results.larger     = larger_q;
	assign results.smaller    = smaller_q;
	assign results.last       = last_q;

endmodule

>>> rtl/mpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/mpa_mac.sv
// Shared multiply-accumulate unit: registered product, then wrapping accumulator.
module mpa_mac #(
	parameter int ELEM_WIDTH = 16,
	localparam int MW = 2 * ELEM_WIDTH,
	localparam int PW = 2 * ELEM_WIDTH + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mpa_pkg::mac_ctrl_t     ctrl,
	input  logic signed [ELEM_WIDTH-1:0] a,
	input  logic signed [ELEM_WIDTH-1:0] b,
	output logic signed [PW-1:0]   acc,
	output logic                   done
);
	import mpa_pkg::*;

	logic signed [MW-1:0] mul_s2;
	logic                 mul_v_s2;
	logic                 mul_first_s2;
	logic                 mul_last_s2;
	logic signed [PW-1:0] acc_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2     <= 1'b0;
			mul_first_s2 <= 1'b0;
			mul_last_s2  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			mul_v_s2     <= ctrl.valid;
			mul_first_s2 <= ctrl.first;
			mul_last_s2  <= ctrl.last;
			if (mul_v_s2 && mul_last_s2) begin
				done_q <= 1'b1;
			end else if (ctrl.take) begin
				done_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		mul_s2 <= a * b;
		if (mul_v_s2) begin
			if (mul_first_s2) begin
				acc_q <= PW'(mul_s2);
			end else begin
				acc_q <= acc_q + PW'(mul_s2);
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;
endmodule

>>> tb/tb_matrix_pair_arithmetic.sv
// Testbench for matrix_pair_arithmetic: directed table, random matrices, scoreboard check.
module tb_matrix_pair_arithmetic;

	// Block geometry; must match the instance parameters below
	localparam int SIDE   = 4;
	localparam int EW     = 16;
	localparam int CELLS  = SIDE * SIDE;
	localparam int SUM_W  = EW + 1;
	localparam int PROD_W = 2 * EW + 2;

	// Run shape
	localparam int RANDOM_ITEMS  = 100;
	localparam int MAX_GAP       = 8;
	localparam int LONG_HOLD     = 300;             // one long back-pressure stretch
	localparam int LONG_HOLD_AT  = 40;              // ... starting at this result
	localparam int DRAIN_CYCLES  = 4 * (SIDE + 4);  // settle time after last result
	localparam int LIMIT_CYCLES  = 200000;
	localparam int PRINT_CAP     = 100;             // mismatch lines shown before going quiet
	localparam int DIRECTED_ROWS = 25;

	// One result transaction as the block should present it
	typedef struct packed {
		logic signed [SUM_W-1:0]  sum;
		logic signed [SUM_W-1:0]  difference;
		logic signed [PROD_W-1:0] product;
		logic signed [EW-1:0]     larger;
		logic signed [EW-1:0]     smaller;
		logic                     last;
	} mpa_result_t;

	// One operand transaction; typed rows carry a hand-written result for the whole matrix
	typedef struct {
		logic signed [EW-1:0] x;
		logic signed [EW-1:0] y;
		bit                   typed;
		mpa_result_t          want;
	} stim_row_t;

	// How a random matrix pair is filled
	typedef enum int {
		FILL_RANDOM,
		FILL_EXTREME,
		FILL_UNIFORM,
		FILL_TIES
	} fill_style_t;

	localparam mpa_result_t NO_CHECK = '0;

	// X and Y both all -32768: every position gives the largest product and smallest sum
	localparam mpa_result_t ALL_MIN_RESULT = '{
		sum:        -65536,
		difference: 0,
		product:    34'sd4294967296,
		larger:     -32768,
		smaller:    -32768,
		last:       1'b1
	};

	logic clk;
	logic arst_n;

	mpa_in_if  #(.ELEM_WIDTH(EW)) opnd ();
	mpa_out_if #(.ELEM_WIDTH(EW)) res ();

	matrix_pair_arithmetic #(
		.SIDE       (SIDE),
		.ELEM_WIDTH (EW)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (opnd),
		.results  (res)
	);

	// Shadow copy of the block's element stores and load position
	logic signed [EW-1:0] x_mat [CELLS];
	logic signed [EW-1:0] y_mat [CELLS];
	int                   load_pos = 0;

	mpa_result_t pending [$];   // results owed by the block, oldest first

	int  mismatches   = 0;
	int  pairs_sent   = 0;
	int  matrices     = 0;
	int  results_seen = 0;
	int  cycles       = 0;
	bit  sender_calm  = 0;
	bit  recv_calm    = 0;

	logic signed [EW-1:0] uniform_x;
	logic signed [EW-1:0] uniform_y;

	logic signed [EW-1:0] extremes [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

	// Directed table: first a full matrix at the negative extreme (hand-checked),
	// then a partial matrix of edge pairs that the random part completes.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b0, NO_CHECK},
		'{-32768, -32768, 1'b1, ALL_MIN_RESULT},
		'{ 32767, -32768, 1'b0, NO_CHECK},     // widest positive difference
		'{-32768,  32767, 1'b0, NO_CHECK},     // widest negative difference
		'{     0,      0, 1'b0, NO_CHECK},
		'{    -1,      1, 1'b0, NO_CHECK},
		'{     1,     -1, 1'b0, NO_CHECK},
		'{ 21845,  21845, 1'b0, NO_CHECK},     // tie: larger takes Y
		'{-21846,  10922, 1'b0, NO_CHECK},
		'{ 32767,  32767, 1'b0, NO_CHECK},     // largest sum
		'{    -1,     -1, 1'b0, NO_CHECK}
	};

	// Store one pair; on the final position fill the whole batch of expected results
	function automatic bit store_pair(input logic signed [EW-1:0] xv,
			input logic signed [EW-1:0] yv, output mpa_result_t batch [CELLS]);
		longint               acc;
		int                   idx;
		logic signed [EW-1:0] a;
		logic signed [EW-1:0] b;
		x_mat[load_pos] = xv;
		y_mat[load_pos] = yv;
		if (load_pos != CELLS - 1) begin
			load_pos++;
			return 1'b0;
		end
		load_pos = 0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				idx = r * SIDE + c;
				a   = x_mat[idx];
				b   = y_mat[idx];
				acc = 0;
				for (int k = 0; k < SIDE; k++)
					acc += longint'(x_mat[r * SIDE + k]) * longint'(y_mat[k * SIDE + c]);
				batch[idx].sum        = SUM_W'(longint'(a) + longint'(b));
				batch[idx].difference = SUM_W'(longint'(a) - longint'(b));
				batch[idx].product    = PROD_W'(acc);
				batch[idx].larger     = (a > b) ? a : b;   // Y wins a tie
				batch[idx].smaller    = (a < b) ? a : b;
				batch[idx].last       = (idx == CELLS - 1);
			end
		end
		return 1'b1;
	endfunction

	function automatic logic signed [EW-1:0] pick_extreme();
		return extremes[$urandom_range(0, 6)];
	endfunction

	function automatic stim_row_t random_row(input fill_style_t style);
		stim_row_t row;
		row.typed = 1'b0;
		row.want  = NO_CHECK;
		case (style)
			FILL_EXTREME: begin
				row.x = pick_extreme();
				row.y = pick_extreme();
			end
			FILL_UNIFORM: begin
				row.x = uniform_x;
				row.y = uniform_y;
			end
			FILL_TIES: begin
				// equal or off by one, wrapping at the ends
				row.x = EW'($urandom_range(0, (1 << EW) - 1));
				row.y = row.x + EW'($urandom_range(0, 2)) - EW'(1);
			end
			default: begin
				row.x = EW'($urandom_range(0, (1 << EW) - 1));
				row.y = EW'($urandom_range(0, (1 << EW) - 1));
			end
		endcase
		return row;
	endfunction

	// Drive one pair, wait for the handshake, then book what the block now owes.
	// valid is only dropped when a gap follows, so back-to-back pairs keep it high.
	task automatic offer_pair(input stim_row_t row);
		int          gap;
		mpa_result_t batch [CELLS];
		mpa_result_t w;
		gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			opnd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opnd.valid     <= 1'b1;
		opnd.x_element <= row.x;
		opnd.y_element <= row.y;
		do @(posedge clk); while (!(opnd.valid && opnd.ready));
		pairs_sent++;
		if (store_pair(row.x, row.y, batch)) begin
			matrices++;
			for (int i = 0; i < CELLS; i++) begin
				if (row.typed) begin
					w      = row.want;
					w.last = (i == CELLS - 1);
				end else begin
					w = batch[i];
				end
				pending.push_back(w);
			end
		end
		if (pairs_sent % CELLS == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			if (mismatches < PRINT_CAP)
				$display("%0t: %s mismatch at position %0d: expected %0d, actual %0d",
					$time, name, results_seen % CELLS, want, got);
			mismatches++;
		end
	endtask

	// Check the result transaction accepted at this edge against the oldest one owed
	task automatic check_result();
		mpa_result_t want;
		if (pending.size() == 0) begin
			if (mismatches < PRINT_CAP)
				$display("%0t: unexpected result: expected none, actual sum %0d diff %0d prod %0d",
					$time, res.sum, res.difference, res.product);
			mismatches++;
		end else begin
			want = pending.pop_front();
			compare_field("sum",        $signed(want.sum),        res.sum);
			compare_field("difference", $signed(want.difference), res.difference);
			compare_field("product",    $signed(want.product),    res.product);
			compare_field("larger",     $signed(want.larger),     res.larger);
			compare_field("smaller",    $signed(want.smaller),    res.smaller);
			compare_field("last",       want.last,                res.last);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT_CYCLES) begin
				$display("Timed out after %0d cycles, %0d results still owed",
					cycles, pending.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Result side: random ready gaps, calm stretches, and one long hold-off so the
	// block backs up and stops taking operands.
	initial begin
		int hold;
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen == LONG_HOLD_AT)
				hold = LONG_HOLD;
			else
				hold = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (hold != 0) begin
				res.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!(res.valid && res.ready));
			check_result();
			results_seen++;
			if (results_seen % CELLS == 0)
				recv_calm = ($urandom_range(0, 3) == 0);
		end
	end

	// Operand side: directed table, then random matrices until the item count is
	// reached and the current matrix is complete.
	initial begin
		fill_style_t style;
		int          rand_items;
		bit          paused;
		opnd.valid     = 1'b0;
		opnd.x_element = '0;
		opnd.y_element = '0;
		style      = FILL_RANDOM;
		rand_items = 0;
		paused     = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (directed_rows[i])
			offer_pair(directed_rows[i]);

		while (rand_items < RANDOM_ITEMS || load_pos != 0) begin
			if (load_pos == 0) begin
				// once, half way: hold off until the block has delivered everything
				if (rand_items >= RANDOM_ITEMS / 2 && !paused) begin
					paused = 1'b1;
					opnd.valid <= 1'b0;
					do @(posedge clk); while (pending.size() != 0);
				end
				style     = fill_style_t'($urandom_range(0, 3));
				uniform_x = pick_extreme();
				uniform_y = pick_extreme();
			end
			offer_pair(random_row(style));
			rand_items++;
		end
		opnd.valid <= 1'b0;

		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d operand pairs forming %0d matrix pairs; checked %0d results.",
			pairs_sent, matrices, results_seen);
		$display("Covered extreme, uniform, tie and random matrices with a %0d-cycle stall.",
			LONG_HOLD);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/mpa_pkg.sv
rtl/mpa_in_if.sv
rtl/mpa_out_if.sv
rtl/mpa_ram.sv
rtl/mpa_mac.sv
rtl/matrix_pair_arithmetic.sv
tb/tb_matrix_pair_arithmetic.sv
